[rtl/mma_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the matrix multiply-accumulate block.
// No dependencies; every other file in rtl imports this package.
package mma_pkg;

  localparam int SZ_W      = 4;   // width of a size register
  localparam int IDX_W     = 3;   // width of a load index
  localparam int AB_W      = 16;  // Q8.8 element
  localparam int C_W       = 32;  // Q16.16 element
  localparam int CFG_IDX_W = 2;
  localparam int DEF_MAX_DIM = 8;
  localparam logic [SZ_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_LOAD_C = 2'd2,
    KIND_START  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ZERO  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_RSVD  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CREAD,
    ST_MAC,
    ST_DRAIN,
    ST_WB
  } state_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [IDX_W-1:0]       row_index;
    logic [IDX_W-1:0]       col_index;
    logic signed [C_W-1:0]  element_value;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]       out_row;
    logic [IDX_W-1:0]       out_col;
    logic signed [C_W-1:0]  out_value;
    logic [1:0]             status;
    logic                   last;
  } out_beat_t;

  // controls from the sequencer to the store modules
  typedef struct packed {
    logic a_we;    // write A entry
    logic b_we;    // write B entry
    logic c_ld;    // write C entry from a load
    logic c_clr;   // write zero into C (clearing pass)
    logic c_wb;    // write accumulator back into C
    logic ab_rd;   // issue A and B reads for one product
    logic acc_ld;  // seed accumulator from C read data
  } ctl_t;

  function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] r, input int maxd);
    return (int'(r) > maxd) ? SZ_W'(maxd) : r;
  endfunction

  function automatic logic signed [C_W-1:0] sat32(input logic signed [C_W:0] s);
    logic signed [C_W-1:0] res;
    if (s[C_W] != s[C_W-1]) begin
      res = s[C_W] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
    end else begin
      res = s[C_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/mma_mac.sv]
`timescale 1ns / 1ps
// A and B element stores with the registered Q8.8 x Q8.8 product.
// Depends on mma_pkg.
module mma_mac #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mma_pkg::ctl_t              ctl,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mma_pkg::AB_W-1:0]   wr_data,
  input  logic [AW-1:0]              a_raddr,
  input  logic [AW-1:0]              b_raddr,
  output logic signed [mma_pkg::C_W-1:0] prod,
  output logic                       prod_v,
  output logic                       busy
);
  import mma_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [AB_W-1:0]        a_mem [DEPTH];
  logic [AB_W-1:0]        b_mem [DEPTH];
  logic signed [AB_W-1:0] a_q_r;
  logic signed [AB_W-1:0] b_q_r;
  logic                   rd_v_r;
  logic signed [C_W-1:0]  prod_r;
  logic                   prod_v_r;

  always_ff @(posedge clk) begin
    if (ctl.a_we) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (ctl.b_we) begin
      b_mem[wr_addr] <= wr_data;
    end
    a_q_r  <= a_mem[a_raddr];
    b_q_r  <= b_mem[b_raddr];
    prod_r <= a_q_r * b_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= ctl.ab_rd;
      prod_v_r <= rd_v_r;
    end
  end

  assign prod   = prod_r;
  assign prod_v = prod_v_r;
  assign busy   = rd_v_r | prod_v_r;

endmodule

[rtl/mma_acc.sv]
`timescale 1ns / 1ps
// C element store and the saturating Q16.16 accumulator.
// Depends on mma_pkg.
module mma_acc #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                           clk,
  input  mma_pkg::ctl_t                  ctl,
  input  logic [AW-1:0]                  wr_addr,
  input  logic signed [mma_pkg::C_W-1:0] ld_data,
  input  logic [AW-1:0]                  c_raddr,
  input  logic signed [mma_pkg::C_W-1:0] prod,
  input  logic                           prod_v,
  output logic signed [mma_pkg::C_W-1:0] acc
);
  import mma_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic signed [C_W-1:0] c_mem [DEPTH];
  logic signed [C_W-1:0] c_q_r;
  logic signed [C_W-1:0] acc_r;
  logic signed [C_W-1:0] wr_val;
  logic                  c_we;

  always_comb begin
    c_we   = ctl.c_clr | ctl.c_ld | ctl.c_wb;
    wr_val = '0;
    if (ctl.c_ld) begin
      wr_val = ld_data;
    end else if (ctl.c_wb) begin
      wr_val = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[wr_addr] <= wr_val;
    end
    c_q_r <= c_mem[c_raddr];
    if (ctl.acc_ld) begin
      acc_r <= c_q_r;
    end else if (prod_v) begin
      acc_r <= sat32({acc_r[C_W-1], acc_r} + {prod[C_W-1], prod});
    end
  end

  assign acc = acc_r;

endmodule

[rtl/mma_seq.sv]
`timescale 1ns / 1ps
// Sequencer: input handshake, load checks, clearing pass and the i/j/p walk.
// Depends on mma_pkg.
module mma_seq #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  mma_pkg::in_beat_t              in_data,
  output logic                           in_stall,
  input  logic [mma_pkg::SZ_W-1:0]       m_size,
  input  logic [mma_pkg::SZ_W-1:0]       k_size,
  input  logic [mma_pkg::SZ_W-1:0]       n_size,
  input  logic                           out_free,
  input  logic                           mac_busy,
  input  logic signed [mma_pkg::C_W-1:0] acc,
  output mma_pkg::ctl_t                  ctl,
  output logic [AW-1:0]                  wr_addr,
  output logic [AW-1:0]                  a_raddr,
  output logic [AW-1:0]                  b_raddr,
  output logic [AW-1:0]                  c_raddr,
  output logic                           res_load,
  output mma_pkg::out_beat_t             res
);
  import mma_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [SZ_W-1:0] i_r, i_nxt;
  logic [SZ_W-1:0] j_r, j_nxt;
  logic [SZ_W-1:0] p_r, p_nxt;
  logic            accept;
  logic            is_start;
  logic            zero_size;
  logic            bad_load;
  logic [SZ_W-1:0] rlim, clim;
  logic [AW-1:0]   ld_addr;
  logic [AW-1:0]   ij_addr;
  logic            last_p, last_j, last_i;

  always_comb begin
    accept    = (state_r == ST_IDLE) && in_valid && out_free;
    is_start  = (in_data.kind == KIND_START);
    zero_size = (m_size == '0) || (k_size == '0) || (n_size == '0);
    rlim      = (in_data.kind == KIND_LOAD_B) ? k_size : m_size;
    clim      = (in_data.kind == KIND_LOAD_A) ? k_size : n_size;
    bad_load  = ({1'b0, in_data.row_index} >= rlim) || ({1'b0, in_data.col_index} >= clim);
    ld_addr   = AW'(int'(in_data.row_index) * MAX_DIM + int'(in_data.col_index));
    ij_addr   = AW'(int'(i_r) * MAX_DIM + int'(j_r));
    last_p    = (p_r == k_size - 1'b1);
    last_j    = (j_r == n_size - 1'b1);
    last_i    = (i_r == m_size - 1'b1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && is_start && !zero_size) begin
          state_nxt = ST_CREAD;
        end
      end
      ST_CREAD: state_nxt = ST_MAC;
      ST_MAC:   if (last_p) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!mac_busy) state_nxt = ST_WB;
      ST_WB: begin
        if (out_free) begin
          state_nxt = (last_i && last_j) ? ST_IDLE : ST_CREAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    clr_nxt = clr_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    p_nxt   = p_r;
    case (state_r)
      ST_CLEAR: clr_nxt = clr_r + 1'b1;
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        p_nxt = '0;
      end
      ST_MAC: p_nxt = p_r + 1'b1;
      ST_WB: begin
        if (out_free) begin
          p_nxt = '0;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    ctl       = '0;
    res_load  = 1'b0;
    res       = '0;
    wr_addr   = ij_addr;
    a_raddr   = AW'(int'(i_r) * MAX_DIM + int'(p_r));
    b_raddr   = AW'(int'(p_r) * MAX_DIM + int'(j_r));
    c_raddr   = ij_addr;
    in_stall  = !((state_r == ST_IDLE) && out_free);
    case (state_r)
      ST_CLEAR: begin
        ctl.c_clr = 1'b1;
        wr_addr   = clr_r;
      end
      ST_IDLE: begin
        wr_addr = ld_addr;
        if (accept) begin
          if (is_start) begin
            if (zero_size) begin
              res_load   = 1'b1;
              res.status = STAT_ZERO;
              res.last   = 1'b1;
            end
          end else if (bad_load) begin
            res_load    = 1'b1;
            res.out_row = in_data.row_index;
            res.out_col = in_data.col_index;
            res.status  = STAT_RANGE;
            res.last    = 1'b1;
          end else begin
            ctl.a_we = (in_data.kind == KIND_LOAD_A);
            ctl.b_we = (in_data.kind == KIND_LOAD_B);
            ctl.c_ld = (in_data.kind == KIND_LOAD_C);
          end
        end
      end
      ST_MAC: begin
        ctl.ab_rd  = 1'b1;
        ctl.acc_ld = (p_r == '0);
      end
      ST_WB: begin
        if (out_free) begin
          ctl.c_wb      = 1'b1;
          res_load      = 1'b1;
          res.out_row   = i_r[IDX_W-1:0];
          res.out_col   = j_r[IDX_W-1:0];
          res.out_value = acc;
          res.status    = STAT_OK;
          res.last      = last_i && last_j;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
    end
  end

endmodule

[rtl/matrix_multiply_accumulate.sv]
`timescale 1ns / 1ps
// Matrix multiply-accumulate top level: C += A x B over local stores.
// Depends on mma_pkg, mma_mac, mma_acc and mma_seq.
//
//   channel | handshake          | beat
//   --------+--------------------+---------------------------------------
//   in_     | in_valid/in_stall  | in_beat_t: kind, row/col index, value
//   out_    | out_valid/out_stall| out_beat_t: row, col, value, status, last
//   cfg_    | cfg_we             | cfg_index, cfg_wdata (4-bit sizes)
//
// A start walks each C element through one C read, k multiply-accumulates
// through the single multiplier, a drain until the product pipeline
// empties and one write-back. After reset a clearing pass zeroes the C
// store, one entry per cycle; no beat is taken until it ends.
// A stalled output holds the write-back step until the result register frees.
module matrix_multiply_accumulate #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  mma_pkg::in_beat_t                 in_data,
  output logic                              in_stall,
  output logic                              out_valid,
  output mma_pkg::out_beat_t                out_data,
  input  logic                              out_stall,
  input  logic                              cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mma_pkg::SZ_W-1:0]          cfg_wdata
);
  import mma_pkg::*;

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  logic [SZ_W-1:0]       rows_a_r, inner_dim_r, cols_b_r;
  logic [SZ_W-1:0]       m_size, k_size, n_size;
  logic                  out_valid_r;
  out_beat_t             out_data_r;
  logic                  out_free;
  ctl_t                  ctl;
  logic [AW-1:0]         wr_addr, a_raddr, b_raddr, c_raddr;
  logic signed [C_W-1:0] prod;
  logic                  prod_v;
  logic                  mac_busy;
  logic signed [C_W-1:0] acc;
  logic                  res_load;
  out_beat_t             res;

  // sizes above MAX_DIM act as MAX_DIM
  always_comb begin
    m_size   = eff_size(rows_a_r, MAX_DIM);
    k_size   = eff_size(inner_dim_r, MAX_DIM);
    n_size   = eff_size(cols_b_r, MAX_DIM);
    out_free = !out_valid_r || !out_stall;
  end

  // size registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= SIZE_RESET;
      inner_dim_r <= SIZE_RESET;
      cols_b_r    <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mma_seq #(.MAX_DIM(MAX_DIM), .AW(AW)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .m_size   (m_size),
    .k_size   (k_size),
    .n_size   (n_size),
    .out_free (out_free),
    .mac_busy (mac_busy),
    .acc      (acc),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .a_raddr  (a_raddr),
    .b_raddr  (b_raddr),
    .c_raddr  (c_raddr),
    .res_load (res_load),
    .res      (res)
  );

  // A/B stores keep the low 16 bits as Q8.8
  mma_mac #(.MAX_DIM(MAX_DIM), .AW(AW)) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_data (in_data.element_value[AB_W-1:0]),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .prod    (prod),
    .prod_v  (prod_v),
    .busy    (mac_busy)
  );

  mma_acc #(.MAX_DIM(MAX_DIM), .AW(AW)) u_acc (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .ld_data (in_data.element_value),
    .c_raddr (c_raddr),
    .prod    (prod),
    .prod_v  (prod_v),
    .acc     (acc)
  );

  // result register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/matrix_multiply_accumulate_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the matrix multiply-accumulate block: loads, starts,
// error beats and size changes, checked against an in-bench fixed-point model.
// Depends on mma_pkg and the matrix_multiply_accumulate RTL.
module matrix_multiply_accumulate_tb;
  import mma_pkg::*;

  localparam int DIM = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_beat_t in_data = '0;
  logic in_stall;
  logic out_valid;
  out_beat_t out_data;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NONE;
  logic [SZ_W-1:0] cfg_wdata = '0;

  matrix_multiply_accumulate #(.MAX_DIM(DIM)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: stores and size registers as the block holds them
  logic [AB_W-1:0] mdl_a [DIM*DIM];
  logic [AB_W-1:0] mdl_b [DIM*DIM];
  logic signed [C_W-1:0] mdl_c [DIM*DIM];
  logic [SZ_W-1:0] mdl_sz [3];

  // stimulus-side bookkeeping: which A and B entries hold real data
  bit a_filled [DIM*DIM];
  bit b_filled [DIM*DIM];
  int gen_m, gen_k, gen_n;

  in_beat_t pending_beats[$];
  out_beat_t expected_beats[$];
  int errors = 0;
  int beats_out = 0;
  int starts_sent = 0;
  int issued = 0;
  int accepted = 0;
  bit quiet = 1'b0;
  int in_gap = 0;
  int out_hold = 0;

  function automatic int clip_size(logic [SZ_W-1:0] r);
    return (int'(r) > DIM) ? DIM : int'(r);
  endfunction

  function automatic out_beat_t mk_beat(int r, int c, logic signed [C_W-1:0] v,
                                        status_t st, bit lst);
    out_beat_t o;
    o.out_row = IDX_W'(r);
    o.out_col = IDX_W'(c);
    o.out_value = v;
    o.status = st;
    o.last = lst;
    return o;
  endfunction

  // Compute the beats one accepted input causes and update the stores.
  function automatic void mac_predict(in_beat_t b);
    int m, k, n, rlim, clim, at;
    longint acc;
    m = clip_size(mdl_sz[CFG_ROWS_A]);
    k = clip_size(mdl_sz[CFG_INNER_DIM]);
    n = clip_size(mdl_sz[CFG_COLS_B]);
    if (b.kind != KIND_START) begin
      rlim = (b.kind == KIND_LOAD_B) ? k : m;
      clim = (b.kind == KIND_LOAD_A) ? k : n;
      if (b.row_index >= rlim || b.col_index >= clim) begin
        expected_beats.push_back(mk_beat(b.row_index, b.col_index, '0, STAT_RANGE, 1'b1));
        return;
      end
      at = b.row_index * DIM + b.col_index;
      case (b.kind)
        KIND_LOAD_A: mdl_a[at] = b.element_value[AB_W-1:0];
        KIND_LOAD_B: mdl_b[at] = b.element_value[AB_W-1:0];
        default:     mdl_c[at] = b.element_value;
      endcase
      return;
    end
    if (m == 0 || k == 0 || n == 0) begin
      expected_beats.push_back(mk_beat(0, 0, '0, STAT_ZERO, 1'b1));
      return;
    end
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = mdl_c[i*DIM+j];
        for (int p = 0; p < k; p++) begin
          acc = acc + longint'($signed(mdl_a[i*DIM+p])) * longint'($signed(mdl_b[p*DIM+j]));
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        end
        mdl_c[i*DIM+j] = C_W'(acc);
        expected_beats.push_back(mk_beat(i, j, C_W'(acc), STAT_OK,
                                         (i == m-1) && (j == n-1)));
      end
    end
  endfunction

  // Queue one beat; mark A/B entries that an in-range load fills.
  task automatic push_beat(kind_t kd, int r, int c, logic [C_W-1:0] v);
    in_beat_t b;
    b.kind = kd;
    b.row_index = IDX_W'(r);
    b.col_index = IDX_W'(c);
    b.element_value = v;
    if (kd == KIND_LOAD_A && r < gen_m && c < gen_k) a_filled[r*DIM+c] = 1'b1;
    if (kd == KIND_LOAD_B && r < gen_k && c < gen_n) b_filled[r*DIM+c] = 1'b1;
    if (kd == KIND_START) starts_sent++;
    pending_beats.push_back(b);
  endtask

  // Start only once every A and B entry the multiply reads holds data.
  task automatic push_start();
    bit zero;
    zero = (gen_m == 0) || (gen_k == 0) || (gen_n == 0);
    if (!zero) begin
      for (int i = 0; i < gen_m; i++)
        for (int p = 0; p < gen_k; p++)
          if (!a_filled[i*DIM+p]) push_beat(KIND_LOAD_A, i, p, $urandom);
      for (int p = 0; p < gen_k; p++)
        for (int j = 0; j < gen_n; j++)
          if (!b_filled[p*DIM+j]) push_beat(KIND_LOAD_B, p, j, $urandom);
    end
    push_beat(KIND_START, 0, 0, $urandom);
  endtask

  // Hold the sender until the block has drained, then let the pipe settle.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_sizes(int m, int k, int n);
    int vals [3];
    vals[0] = m; vals[1] = k; vals[2] = n;
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= SZ_W'(vals[i]);
      mdl_sz[i] = SZ_W'(vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_index <= CFG_NONE;
    gen_m = clip_size(SZ_W'(m));
    gen_k = clip_size(SZ_W'(k));
    gen_n = clip_size(SZ_W'(n));
  endtask

  // Random mix: mostly in-range loads and starts, some stray indices.
  task automatic random_beats(int cnt);
    int sel, r, c, lim_r, lim_c;
    kind_t kd;
    logic [C_W-1:0] v;
    for (int t = 0; t < cnt; t++) begin
      sel = $urandom_range(0, 9);
      if (sel >= 8) begin
        push_start();
      end else begin
        kd = kind_t'($urandom_range(0, 2));
        lim_r = (kd == KIND_LOAD_B) ? gen_k : gen_m;
        lim_c = (kd == KIND_LOAD_A) ? gen_k : gen_n;
        if ($urandom_range(0, 7) == 0 || lim_r == 0 || lim_c == 0) begin
          r = $urandom_range(0, 7);
          c = $urandom_range(0, 7);
        end else begin
          r = $urandom_range(0, lim_r - 1);
          c = $urandom_range(0, lim_c - 1);
        end
        case ($urandom_range(0, 5))
          0: v = 32'h0000_7FFF;
          1: v = 32'hFFFF_8000;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = $urandom;
        endcase
        if (kd == KIND_LOAD_C) v = $urandom_range(0, 3) == 0 ? v : ($urandom >>> 8);
        push_beat(kd, r, c, v);
      end
    end
  endtask

  // Driver: present the next beat at the falling edge once the last one went.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accepted == issued) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        issued = issued + 1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts, none in the quiet tail.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 7) == 0) out_hold = $urandom_range(1, 8);
    end
  end

  // Monitor: predict on accepted inputs, check accepted outputs in order.
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        mac_predict(in_data);
        accepted = accepted + 1;
      end
      if (out_valid && !out_stall) begin
        beats_out = beats_out + 1;
        if (expected_beats.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected beat %h", $time, out_data);
        end else begin
          e = expected_beats.pop_front();
          if (out_data.out_row !== e.out_row || out_data.out_col !== e.out_col ||
              out_data.out_value !== e.out_value || out_data.status !== e.status ||
              out_data.last !== e.last) begin
            errors = errors + 1;
            $display("%0t: mismatch expected row %0d col %0d val %h st %0d last %0d",
                     $time, e.out_row, e.out_col, e.out_value, e.status, e.last);
            $display("%0t:          actual   row %0d col %0d val %h st %0d last %0d",
                     $time, out_data.out_row, out_data.out_col, out_data.out_value,
                     out_data.status, out_data.last);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < DIM*DIM; i++) begin
      mdl_a[i] = '0; mdl_b[i] = '0; mdl_c[i] = '0;
      a_filled[i] = 1'b0; b_filled[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) mdl_sz[i] = SIZE_RESET;
    gen_m = DIM; gen_k = DIM; gen_n = DIM;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // let the C clearing pass run out
    repeat (DIM*DIM + 16) @(posedge clk);

    // directed: saturation both ways, range errors on every load kind
    set_sizes(2, 2, 2);
    push_beat(KIND_LOAD_A, 0, 0, 32'h0000_7FFF);
    push_beat(KIND_LOAD_A, 0, 1, 32'h1234_7FFF);
    push_beat(KIND_LOAD_A, 1, 0, 32'hFFFF_8000);
    push_beat(KIND_LOAD_A, 1, 1, 32'h0000_8000);
    push_beat(KIND_LOAD_B, 0, 0, 32'h0000_7FFF);
    push_beat(KIND_LOAD_B, 1, 0, 32'h0000_7FFF);
    push_beat(KIND_LOAD_B, 0, 1, 32'h0000_0000);
    push_beat(KIND_LOAD_B, 1, 1, 32'h0000_FFFF);
    push_beat(KIND_LOAD_C, 0, 0, 32'h7FFF_FFFF);
    push_beat(KIND_LOAD_C, 1, 0, 32'h8000_0000);
    push_start();
    push_start();
    push_beat(KIND_LOAD_A, 7, 7, 32'hFFFF_FFFF);
    push_beat(KIND_LOAD_B, 2, 0, 32'h0);
    push_beat(KIND_LOAD_C, 0, 2, 32'h0);
    wait_idle();

    // zero sizes: start errors, an A load out of range and an in-range B load
    set_sizes(0, 3, 3);
    push_start();
    push_beat(KIND_LOAD_A, 0, 0, 32'h1);
    push_beat(KIND_LOAD_B, 0, 0, 32'h1);
    wait_idle();
    set_sizes(3, 0, 3);
    push_start();
    wait_idle();
    set_sizes(3, 3, 0);
    push_start();
    wait_idle();

    // oversized registers act as the full size
    set_sizes(15, 15, 15);
    random_beats(8);
    push_start();
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      set_sizes($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 4));
      random_beats(8);
      wait_idle();
    end
    set_sizes(1, 1, 1);
    random_beats(12);
    wait_idle();
    set_sizes(8, 1, 8);
    random_beats(10);
    push_start();
    wait_idle();

    quiet = 1'b1;
    set_sizes(3, 2, 4);
    random_beats(20);
    wait_idle();
    repeat (50) @(posedge clk);

    $display("covered %0d inputs, %0d starts, %0d output beats checked over varied sizes",
             accepted, starts_sent, beats_out);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
